@@ src/drms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the drive run-mode sequencer.
// No dependencies.
package drms_pkg;

    localparam int SENSOR_CHANNELS = 12;
    localparam int SENSOR_W        = 12;
    localparam int TICK_W          = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 24;

    // Channels beyond the sensor field width never count.
    localparam logic [SENSOR_W-1:0] C_BLACK_MASK =
        SENSOR_W'((64'd1 << SENSOR_CHANNELS) - 64'd1);

    localparam logic [7:0]  C_STREAK_MAX = 8'd255;
    localparam logic [23:0] C_PREPARE_TICKS_RST = 24'd3000;
    localparam logic [23:0] C_GUARD_TICKS_RST   = 24'd1000;
    localparam logic [7:0]  C_STOP_STREAK_RST   = 8'd3;
    localparam logic [11:0] C_BASE_SPEED_RST    = 12'd1000;
    localparam logic [14:0] C_CORR_LIMIT_RST    = 15'd8192;

    // Q2.14 unity
    localparam logic signed [16:0] C_Q14_ONE = 17'sd16384;

    localparam logic [CFG_INDEX_W-1:0] CFG_PREPARE_TICKS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GUARD_TICKS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_STREAK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SPEED    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CORR_LIMIT    = 3'd4;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_PREP = 2'd1,
        PH_ON   = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MD_IDLE     = 2'd0,
        MD_STRAIGHT = 2'd1,
        MD_TRACK    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ACT_ZERO     = 2'd0,
        ACT_STRAIGHT = 2'd1,
        ACT_TRACK    = 2'd2
    } t_action;

endpackage

@@ src/drive_run_mode_sequencer_core.sv @@
`timescale 1ns / 1ps
// An input is captured in the input register, then its result in the result register;
// the phase/mode update and the two speed products sit between.
// Throughput: one item per cycle, as long as the result side does not stall.
// Reset (i_rst_n low, synchronous): phase off, mode idle, history cleared,
// configuration registers back to their defaults, both stages empty.
module drive_run_mode_sequencer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [drms_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [drms_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_reset_event,
    input  logic                                 i_mode_event,
    input  logic                                 i_toggle_event,
    input  logic [drms_pkg::TICK_W-1:0]          i_now_tick,
    input  logic                                 i_sensor_read_ok,
    input  logic [drms_pkg::SENSOR_W-1:0]        i_sensor_bits,
    input  logic signed [15:0]                   i_sensor_weight,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_run_phase,
    output logic [1:0]                           o_drive_mode,
    output logic [1:0]                           o_loop_action,
    output logic                                 o_controller_clear,
    output logic                                 o_guard_open,
    output logic signed [15:0]                   o_steer_correction,
    output logic signed [14:0]                   o_left_speed_target,
    output logic signed [14:0]                   o_right_speed_target
);
    import drms_pkg::*;

    // configuration
    logic [23:0] r_prepare_ticks;
    logic [23:0] r_guard_ticks;
    logic [7:0]  r_stop_streak;
    logic [11:0] r_base_speed;
    logic [14:0] r_corr_limit;

    // input stage
    logic                 r_in_valid;
    logic                 r_reset_ev;
    logic                 r_mode_ev;
    logic                 r_toggle_ev;
    logic [TICK_W-1:0]    r_now;
    logic                 r_read_ok;
    logic [SENSOR_W-1:0]  r_bits;
    logic signed [15:0]   r_weight;

    // sequencer state
    t_phase               r_phase;
    t_mode                r_mode;
    logic [TICK_W-1:0]    r_prep_start;
    logic                 r_guard_armed;
    logic [TICK_W-1:0]    r_guard_deadline;
    logic [7:0]           r_streak;
    logic signed [15:0]   r_held_weight;
    logic                 r_held_valid;

    // next state
    t_phase               n_phase;
    t_mode                n_mode;
    logic [TICK_W-1:0]    n_prep_start;
    logic                 n_guard_armed;
    logic [TICK_W-1:0]    n_guard_deadline;
    logic [7:0]           n_streak;
    logic signed [15:0]   n_held_weight;
    logic                 n_held_valid;
    logic                 n_clear;
    t_action              n_action;
    logic                 n_guard_open;
    logic signed [15:0]   n_corr;
    logic signed [14:0]   n_left;
    logic signed [14:0]   n_right;

    // result stage
    logic                 r_out_valid;
    logic [1:0]           r_run_phase;
    logic [1:0]           r_drive_mode;
    logic [1:0]           r_loop_action;
    logic                 r_clear;
    logic                 r_guard_open;
    logic signed [15:0]   r_corr;
    logic signed [14:0]   r_left;
    logic signed [14:0]   r_right;

    logic                 w_adv;
    logic                 w_in_take;
    logic                 w_black;
    logic [TICK_W-1:0]    w_prep_elapsed;
    logic [TICK_W-1:0]    w_guard_diff;
    logic signed [16:0]   w_weight;
    logic signed [16:0]   w_lim;
    logic signed [16:0]   w_fac_l;
    logic signed [16:0]   w_fac_r;
    logic signed [29:0]   w_prod_l;
    logic signed [29:0]   w_prod_r;
    logic signed [29:0]   w_rnd_l;
    logic signed [29:0]   w_rnd_r;

    assign o_cfg_ready = 1'b1;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_black = r_read_ok && ((r_bits & C_BLACK_MASK) != '0);
    assign w_lim   = $signed({2'b00, r_corr_limit});

    always_comb begin
        n_phase          = r_phase;
        n_mode           = r_mode;
        n_prep_start     = r_prep_start;
        n_guard_armed    = r_guard_armed;
        n_guard_deadline = r_guard_deadline;
        n_streak         = r_streak;
        n_held_weight    = r_held_weight;
        n_held_valid     = r_held_valid;
        n_clear          = 1'b0;
        n_action         = ACT_ZERO;
        n_guard_open     = 1'b0;
        w_weight         = '0;
        w_prep_elapsed   = '0;
        w_guard_diff     = '0;

        // button events: reset wins over mode and toggle
        if (r_reset_ev) begin
            n_mode       = MD_IDLE;
            n_phase      = PH_OFF;
            n_streak     = '0;
            n_clear      = 1'b1;
            n_prep_start = '0;
        end else begin
            if (r_mode_ev) begin
                unique case (r_mode)
                    MD_IDLE:     n_mode = MD_STRAIGHT;
                    MD_STRAIGHT: n_mode = MD_TRACK;
                    MD_TRACK:    n_mode = MD_IDLE;
                    default:     n_mode = MD_STRAIGHT;
                endcase
                n_phase  = PH_OFF;
                n_streak = '0;
                n_clear  = 1'b1;
            end
            if (r_toggle_ev) begin
                if (n_phase == PH_OFF) begin
                    if (n_mode != MD_IDLE) begin
                        n_phase      = PH_PREP;
                        n_streak     = '0;
                        n_clear      = 1'b1;
                        n_prep_start = r_now;
                    end
                end else if (n_phase == PH_PREP || n_phase == PH_ON) begin
                    n_phase  = PH_OFF;
                    n_streak = '0;
                    n_clear  = 1'b1;
                end
            end
        end

        w_prep_elapsed = r_now - n_prep_start;
        if (n_phase == PH_PREP && w_prep_elapsed >= {8'd0, r_prepare_ticks}) begin
            n_phase  = PH_ON;
            n_streak = '0;
            n_clear  = 1'b1;
        end

        // a phase entry from the events or the prepare timer drops the history
        if (n_clear) begin
            n_guard_armed    = 1'b0;
            n_guard_deadline = '0;
            n_held_weight    = '0;
            n_held_valid     = 1'b0;
        end

        // every path except straight/track in phase on drops the history
        if (n_phase != PH_ON) begin
            n_guard_armed    = 1'b0;
            n_guard_deadline = '0;
            n_held_weight    = '0;
            n_held_valid     = 1'b0;
        end else begin
            unique case (n_mode)
                MD_STRAIGHT: begin
                    if (!n_guard_armed) begin
                        n_guard_armed    = 1'b1;
                        n_guard_deadline = r_now + {8'd0, r_guard_ticks};
                    end
                    w_guard_diff  = r_now - n_guard_deadline;
                    n_guard_open  = w_guard_diff[TICK_W-1];
                    n_held_weight = '0;
                    n_held_valid  = 1'b0;
                    if (n_guard_open) begin
                        n_streak = '0;
                        n_action = ACT_STRAIGHT;
                    end else begin
                        if (w_black) begin
                            if (n_streak < C_STREAK_MAX) begin
                                n_streak = n_streak + 8'd1;
                            end
                        end else begin
                            n_streak = '0;
                        end
                        if (n_streak >= r_stop_streak) begin
                            n_phase  = PH_STOP;
                            n_streak = '0;
                            n_clear  = 1'b1;
                            n_mode   = MD_IDLE;
                        end else begin
                            n_action = ACT_STRAIGHT;
                        end
                    end
                end
                MD_TRACK: begin
                    n_streak         = '0;
                    n_guard_armed    = 1'b0;
                    n_guard_deadline = '0;
                    if (w_black) begin
                        w_weight      = 17'(r_weight);
                        n_held_weight = r_weight;
                        n_held_valid  = 1'b1;
                    end else if (n_held_valid) begin
                        w_weight = 17'(n_held_weight);
                    end
                    if (w_weight < -w_lim) begin
                        w_weight = -w_lim;
                    end
                    if (w_weight > w_lim) begin
                        w_weight = w_lim;
                    end
                    n_action = ACT_TRACK;
                end
                MD_IDLE: begin
                    n_streak         = '0;
                    n_guard_armed    = 1'b0;
                    n_guard_deadline = '0;
                    n_held_weight    = '0;
                    n_held_valid     = 1'b0;
                end
                default: begin
                    n_guard_armed    = 1'b0;
                    n_guard_deadline = '0;
                    n_held_weight    = '0;
                    n_held_valid     = 1'b0;
                    n_phase          = PH_OFF;
                    n_streak         = '0;
                    n_clear          = 1'b1;
                end
            endcase
        end
    end

    // track speeds: base * (1 -/+ c), rounded half away from zero
    assign n_corr   = w_weight[15:0];
    assign w_fac_l  = C_Q14_ONE - w_weight;
    assign w_fac_r  = C_Q14_ONE + w_weight;
    assign w_prod_l = $signed({1'b0, r_base_speed}) * w_fac_l;
    assign w_prod_r = $signed({1'b0, r_base_speed}) * w_fac_r;
    assign w_rnd_l  = (w_prod_l + (w_prod_l[29] ? 30'sd8191 : 30'sd8192)) >>> 14;
    assign w_rnd_r  = (w_prod_r + (w_prod_r[29] ? 30'sd8191 : 30'sd8192)) >>> 14;
    assign n_left   = (n_action == ACT_TRACK) ? w_rnd_l[14:0] : '0;
    assign n_right  = (n_action == ACT_TRACK) ? w_rnd_r[14:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prepare_ticks  <= C_PREPARE_TICKS_RST;
            r_guard_ticks    <= C_GUARD_TICKS_RST;
            r_stop_streak    <= C_STOP_STREAK_RST;
            r_base_speed     <= C_BASE_SPEED_RST;
            r_corr_limit     <= C_CORR_LIMIT_RST;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_phase          <= PH_OFF;
            r_mode           <= MD_IDLE;
            r_prep_start     <= '0;
            r_guard_armed    <= 1'b0;
            r_guard_deadline <= '0;
            r_streak         <= '0;
            r_held_weight    <= '0;
            r_held_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PREPARE_TICKS: r_prepare_ticks <= i_cfg_data;
                    CFG_GUARD_TICKS:   r_guard_ticks   <= i_cfg_data;
                    CFG_STOP_STREAK:   r_stop_streak   <= i_cfg_data[7:0];
                    CFG_BASE_SPEED:    r_base_speed    <= i_cfg_data[11:0];
                    CFG_CORR_LIMIT:    r_corr_limit    <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_phase          <= n_phase;
                    r_mode           <= n_mode;
                    r_prep_start     <= n_prep_start;
                    r_guard_armed    <= n_guard_armed;
                    r_guard_deadline <= n_guard_deadline;
                    r_streak         <= n_streak;
                    r_held_weight    <= n_held_weight;
                    r_held_valid     <= n_held_valid;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_reset_ev  <= i_reset_event;
            r_mode_ev   <= i_mode_event;
            r_toggle_ev <= i_toggle_event;
            r_now       <= i_now_tick;
            r_read_ok   <= i_sensor_read_ok;
            r_bits      <= i_sensor_bits;
            r_weight    <= i_sensor_weight;
        end
        if (w_adv && r_in_valid) begin
            r_run_phase   <= n_phase;
            r_drive_mode  <= n_mode;
            r_loop_action <= n_action;
            r_clear       <= n_clear;
            r_guard_open  <= n_guard_open;
            r_corr        <= n_corr;
            r_left        <= n_left;
            r_right       <= n_right;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_run_phase          = r_run_phase;
    assign o_drive_mode         = r_drive_mode;
    assign o_loop_action        = r_loop_action;
    assign o_controller_clear   = r_clear;
    assign o_guard_open         = r_guard_open;
    assign o_steer_correction   = r_corr;
    assign o_left_speed_target  = r_left;
    assign o_right_speed_target = r_right;

    // track action only comes out of phase on in track mode
    a_track_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_loop_action == ACT_TRACK) |->
        (o_drive_mode == MD_TRACK && o_run_phase == PH_ON))
        else $error("track action outside track/on");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_loop_action != ACT_TRACK) |->
        (o_steer_correction == 16'sd0 && o_left_speed_target == 15'sd0
         && o_right_speed_target == 15'sd0))
        else $error("steering outputs nonzero outside track");

    a_guard_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_guard_open) |-> (o_loop_action == ACT_STRAIGHT))
        else $error("guard open without straight action");

    a_corr_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_loop_action == ACT_TRACK) |->
        (17'(o_steer_correction) <= w_lim && 17'(o_steer_correction) >= -w_lim))
        else $error("steer correction beyond limit");

endmodule

@@ bench/drms_result_checker.sv @@
`timescale 1ns / 1ps
// Checker for the drive run-mode sequencer: watches the config, input and result
// channels, predicts each result and compares it. Depends on drms_pkg.
module drms_result_checker
    import drms_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_reset_event,
    input  logic                       i_mode_event,
    input  logic                       i_toggle_event,
    input  logic [TICK_W-1:0]          i_now_tick,
    input  logic                       i_sensor_read_ok,
    input  logic [SENSOR_W-1:0]        i_sensor_bits,
    input  logic signed [15:0]         i_sensor_weight,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_run_phase,
    input  logic [1:0]                 i_drive_mode,
    input  logic [1:0]                 i_loop_action,
    input  logic                       i_controller_clear,
    input  logic                       i_guard_open,
    input  logic signed [15:0]         i_steer_correction,
    input  logic signed [14:0]         i_left_speed_target,
    input  logic signed [14:0]         i_right_speed_target,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [1:0]         phase;
        logic [1:0]         mode;
        logic [1:0]         action;
        logic               clear;
        logic               guard;
        logic signed [15:0] steer;
        logic signed [14:0] left;
        logic signed [14:0] right;
    } seq_result_t;

    localparam int PRINT_CAP = 100;

    // configuration copy
    logic [23:0] prep_ticks_q;
    logic [23:0] guard_ticks_q;
    logic [7:0]  stop_streak_q;
    logic [11:0] base_speed_q;
    logic [14:0] corr_limit_q;

    // sequencer state copy
    t_phase             phase_q;
    logic [1:0]         mode_q;
    logic [31:0]        prep_start_q;
    logic               guard_armed_q;
    logic [31:0]        guard_deadline_q;
    logic [7:0]         black_run_q;
    logic signed [15:0] held_weight_q;
    logic               held_valid_q;
    logic               clear_now;

    seq_result_t expected_q[$];
    seq_result_t want;
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(string what, longint got, longint exp_val);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns checker: %s got %0d wanted %0d", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic void drop_history();
        guard_armed_q    = 1'b0;
        guard_deadline_q = '0;
        held_weight_q    = '0;
        held_valid_q     = 1'b0;
    endfunction

    function automatic void enter_phase(t_phase ph);
        phase_q     = ph;
        black_run_q = '0;
        clear_now   = 1'b1;
    endfunction

    // base_speed * factor / 2^14, nearest, ties away from zero
    function automatic logic signed [14:0] scaled_speed(int factor);
        longint prod;
        prod = longint'(base_speed_q) * longint'(factor);
        if (prod >= 0)
            prod = (prod + 8192) >>> 14;
        else
            prod = -((-prod + 8192) >>> 14);
        return prod[14:0];
    endfunction

    function automatic seq_result_t step_sequencer(
        logic rst_ev, logic mode_ev, logic tog_ev, logic [31:0] now,
        logic read_ok, logic [SENSOR_W-1:0] bits, logic signed [15:0] weight);
        seq_result_t r;
        logic [31:0] since;
        logic        black;
        int          w;
        int          lim;
        r         = '0;
        clear_now = 1'b0;
        black     = read_ok && ((bits & C_BLACK_MASK) != '0);

        // button events: reset wins over mode and toggle
        if (rst_ev) begin
            mode_q = MD_IDLE;
            enter_phase(PH_OFF);
            prep_start_q = '0;
            drop_history();
        end else begin
            if (mode_ev) begin
                case (mode_q)
                    MD_IDLE:     mode_q = MD_STRAIGHT;
                    MD_STRAIGHT: mode_q = MD_TRACK;
                    MD_TRACK:    mode_q = MD_IDLE;
                    default:     mode_q = MD_STRAIGHT;
                endcase
                enter_phase(PH_OFF);
                drop_history();
            end
            if (tog_ev) begin
                if (phase_q == PH_OFF) begin
                    if (mode_q != MD_IDLE) begin
                        enter_phase(PH_PREP);
                        prep_start_q = now;
                        drop_history();
                    end
                end else if (phase_q == PH_PREP || phase_q == PH_ON) begin
                    enter_phase(PH_OFF);
                    drop_history();
                end
            end
        end

        since = now - prep_start_q;
        if (phase_q == PH_PREP && since >= 32'(prep_ticks_q)) begin
            enter_phase(PH_ON);
            drop_history();
        end

        if (phase_q != PH_ON) begin
            drop_history();
        end else if (mode_q == MD_IDLE) begin
            black_run_q = '0;
            drop_history();
        end else if (mode_q == MD_STRAIGHT) begin
            if (!guard_armed_q) begin
                guard_armed_q    = 1'b1;
                guard_deadline_q = now + 32'(guard_ticks_q);
            end
            since         = now - guard_deadline_q;
            r.guard       = since[31];
            held_weight_q = '0;
            held_valid_q  = 1'b0;
            if (r.guard) begin
                black_run_q = '0;
                r.action    = ACT_STRAIGHT;
            end else begin
                if (black) begin
                    if (black_run_q < C_STREAK_MAX)
                        black_run_q++;
                end else begin
                    black_run_q = '0;
                end
                if (black_run_q >= stop_streak_q) begin
                    enter_phase(PH_STOP);
                    mode_q = MD_IDLE;
                end else begin
                    r.action = ACT_STRAIGHT;
                end
            end
        end else if (mode_q == MD_TRACK) begin
            black_run_q      = '0;
            guard_armed_q    = 1'b0;
            guard_deadline_q = '0;
            if (black) begin
                w             = int'(weight);
                held_weight_q = weight;
                held_valid_q  = 1'b1;
            end else begin
                w = held_valid_q ? int'(held_weight_q) : 0;
            end
            lim = int'(corr_limit_q);
            if (w < -lim)
                w = -lim;
            if (w > lim)
                w = lim;
            r.steer  = 16'(w);
            r.left   = scaled_speed(int'(C_Q14_ONE) - w);
            r.right  = scaled_speed(int'(C_Q14_ONE) + w);
            r.action = ACT_TRACK;
        end else begin
            // mode three falls back to off
            drop_history();
            enter_phase(PH_OFF);
        end

        r.phase = phase_q;
        r.mode  = mode_q;
        r.clear = clear_now;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prep_ticks_q  = C_PREPARE_TICKS_RST;
            guard_ticks_q = C_GUARD_TICKS_RST;
            stop_streak_q = C_STOP_STREAK_RST;
            base_speed_q  = C_BASE_SPEED_RST;
            corr_limit_q  = C_CORR_LIMIT_RST;
            phase_q       = PH_OFF;
            mode_q        = MD_IDLE;
            prep_start_q  = '0;
            black_run_q   = '0;
            clear_now     = 1'b0;
            drop_history();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PREPARE_TICKS: prep_ticks_q  = i_cfg_data[23:0];
                    CFG_GUARD_TICKS:   guard_ticks_q = i_cfg_data[23:0];
                    CFG_STOP_STREAK:   stop_streak_q = i_cfg_data[7:0];
                    CFG_BASE_SPEED:    base_speed_q  = i_cfg_data[11:0];
                    CFG_CORR_LIMIT:    corr_limit_q  = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_run_phase !== want.phase)
                        report_mismatch("run_phase", i_run_phase, want.phase);
                    if (i_drive_mode !== want.mode)
                        report_mismatch("drive_mode", i_drive_mode, want.mode);
                    if (i_loop_action !== want.action)
                        report_mismatch("loop_action", i_loop_action, want.action);
                    if (i_controller_clear !== want.clear)
                        report_mismatch("controller_clear", i_controller_clear, want.clear);
                    if (i_guard_open !== want.guard)
                        report_mismatch("guard_open", i_guard_open, want.guard);
                    if (i_steer_correction !== want.steer)
                        report_mismatch("steer_correction", i_steer_correction, want.steer);
                    if (i_left_speed_target !== want.left)
                        report_mismatch("left_speed_target", i_left_speed_target, want.left);
                    if (i_right_speed_target !== want.right)
                        report_mismatch("right_speed_target", i_right_speed_target,
                                        want.right);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(step_sequencer(i_reset_event, i_mode_event,
                    i_toggle_event, i_now_tick, i_sensor_read_ok, i_sensor_bits,
                    i_sensor_weight));
        end
        o_pending <= expected_q.size();
    end

endmodule

@@ bench/drive_run_mode_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the drive run-mode sequencer bench: clock, reset, stimulus and verdict.
// Depends on drms_pkg, drive_run_mode_sequencer_core and drms_result_checker.
module drive_run_mode_sequencer_core_tb;
    import drms_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SETTINGS_CNT   = 8;
    localparam int ITEMS_PER_SET  = 20;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_reset_event;
    logic                    i_mode_event;
    logic                    i_toggle_event;
    logic [TICK_W-1:0]       i_now_tick;
    logic                    i_sensor_read_ok;
    logic [SENSOR_W-1:0]     i_sensor_bits;
    logic signed [15:0]      i_sensor_weight;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_run_phase;
    logic [1:0]              o_drive_mode;
    logic [1:0]              o_loop_action;
    logic                    o_controller_clear;
    logic                    o_guard_open;
    logic signed [15:0]      o_steer_correction;
    logic signed [14:0]      o_left_speed_target;
    logic signed [14:0]      o_right_speed_target;

    int          fail_count;
    int          pending;
    int          stall_hold = 0;
    int          quiet_cycles = 0;
    int          sent_items = 0;
    bit          calm_in = 1'b0;
    logic [31:0] tick_now = '0;

    drive_run_mode_sequencer_core uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_reset_event        (i_reset_event),
        .i_mode_event         (i_mode_event),
        .i_toggle_event       (i_toggle_event),
        .i_now_tick           (i_now_tick),
        .i_sensor_read_ok     (i_sensor_read_ok),
        .i_sensor_bits        (i_sensor_bits),
        .i_sensor_weight      (i_sensor_weight),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_run_phase          (o_run_phase),
        .o_drive_mode         (o_drive_mode),
        .o_loop_action        (o_loop_action),
        .o_controller_clear   (o_controller_clear),
        .o_guard_open         (o_guard_open),
        .o_steer_correction   (o_steer_correction),
        .o_left_speed_target  (o_left_speed_target),
        .o_right_speed_target (o_right_speed_target)
    );

    drms_result_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_reset_event        (i_reset_event),
        .i_mode_event         (i_mode_event),
        .i_toggle_event       (i_toggle_event),
        .i_now_tick           (i_now_tick),
        .i_sensor_read_ok     (i_sensor_read_ok),
        .i_sensor_bits        (i_sensor_bits),
        .i_sensor_weight      (i_sensor_weight),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_run_phase          (o_run_phase),
        .i_drive_mode         (o_drive_mode),
        .i_loop_action        (o_loop_action),
        .i_controller_clear   (o_controller_clear),
        .i_guard_open         (o_guard_open),
        .i_steer_correction   (o_steer_correction),
        .i_left_speed_target  (o_left_speed_target),
        .i_right_speed_target (o_right_speed_target),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] step_tick(int stride);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return $urandom;
        if (r < 10)
            return tick_now + $urandom_range(0, 5000);
        return tick_now + $urandom_range(0, stride);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_hold  <= pick_gap();
            i_out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("drive_run_mode_sequencer_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(bit rst_ev, bit mode_ev, bit tog_ev, logic [31:0] tick,
                             bit read_ok, logic [11:0] bits, logic signed [15:0] weight);
        int gap;
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_reset_event    <= rst_ev;
        i_mode_event     <= mode_ev;
        i_toggle_event   <= tog_ev;
        i_now_tick       <= tick;
        i_sensor_read_ok <= read_ok;
        i_sensor_bits    <= bits;
        i_sensor_weight  <= weight;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [23:0] prep, logic [23:0] guard, logic [23:0] streak,
                                 logic [23:0] base, logic [23:0] limit);
        write_reg(CFG_PREPARE_TICKS, prep);
        write_reg(CFG_GUARD_TICKS, guard);
        write_reg(CFG_STOP_STREAK, streak);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_CORR_LIMIT, limit);
        i_cfg_valid <= 1'b0;
    endtask

    // reset (not on every call), step to a mode, start the run, then a stretch of sensor periods
    task automatic run_sequence(int run_len, int black_pct, int stride, int mode_steps,
                                bit calm);
        int                 n;
        bit                 read_ok;
        logic [11:0]        bits;
        logic signed [15:0] weight;
        logic [2:0]         ev;
        calm_in = calm || ($urandom_range(0, 3) == 0);
        if (calm || $urandom_range(0, 3) != 0) begin
            tick_now = step_tick(stride);
            send_item(1'b1, 1'b0, 1'b0, tick_now, $urandom_range(0, 1), 12'($urandom),
                      16'($urandom));
        end
        repeat (mode_steps) begin
            tick_now = step_tick(stride);
            send_item(1'b0, 1'b1, 1'b0, tick_now, 1'b0, '0, '0);
        end
        tick_now = step_tick(stride);
        send_item(1'b0, 1'b0, 1'b1, tick_now, 1'b0, '0, '0);
        for (n = 0; n < run_len; n++) begin
            ev = 3'b000;
            if (!calm && $urandom_range(0, 24) == 0)
                ev = 3'(1 << $urandom_range(0, 2));
            if ($urandom_range(0, 99) < black_pct) begin
                read_ok = 1'b1;
                bits    = 12'($urandom_range(1, 4095));
            end else if ($urandom_range(0, 1) == 0) begin
                read_ok = 1'b1;
                bits    = '0;
            end else begin
                read_ok = 1'b0;
                bits    = 12'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
                weight = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
            else
                weight = 16'($urandom);
            tick_now = step_tick(stride);
            send_item(ev[2], ev[1], ev[0], tick_now, read_ok, bits, weight);
        end
    endtask

    initial begin
        int k;
        int goal;
        int stride;
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_reset_event    <= 1'b0;
        i_mode_event     <= 1'b0;
        i_toggle_event   <= 1'b0;
        i_now_tick       <= '0;
        i_sensor_read_ok <= 1'b0;
        i_sensor_bits    <= '0;
        i_sensor_weight  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset configuration
        send_item(0, 0, 0, 32'd100, 0, 12'h000, 16'sd0);
        send_item(0, 0, 1, 32'd101, 1, 12'hFFF, 16'sh7FFF);  // toggle ignored in idle
        send_item(0, 1, 1, 32'd200, 1, 12'h000, 16'sd0);     // straight, then prepare
        send_item(0, 0, 0, 32'd3199, 1, 12'hFFF, 16'sd0);
        send_item(0, 0, 0, 32'd3200, 0, 12'hFFF, 16'sd0);    // on, guard opens
        send_item(0, 0, 0, 32'd4199, 1, 12'h001, 16'sd0);
        send_item(0, 0, 0, 32'd4200, 1, 12'h800, 16'sd0);    // guard closed
        send_item(0, 0, 0, 32'd4201, 1, 12'hFFF, 16'sd0);
        send_item(0, 0, 0, 32'd4202, 1, 12'h000, 16'sd0);    // streak broken
        send_item(0, 0, 0, 32'd4203, 1, 12'h020, 16'sd0);
        send_item(0, 0, 0, 32'd4204, 1, 12'h040, 16'sd0);
        send_item(0, 0, 0, 32'd4205, 1, 12'h080, 16'sd0);    // black-line stop
        send_item(0, 0, 1, 32'd4206, 0, 12'h000, 16'sd0);    // toggle ignored in stop
        send_item(1, 1, 1, 32'd4207, 1, 12'hFFF, -16'sd1);   // reset drops the rest
        send_item(0, 1, 0, 32'd4208, 0, 12'h000, 16'sd0);
        send_item(0, 1, 0, 32'd4209, 0, 12'h000, 16'sd0);    // track
        send_item(0, 0, 1, 32'd4210, 0, 12'h000, 16'sd0);
        send_item(0, 0, 0, 32'd7210, 1, 12'h010, 16'sh7FFF); // clamped high
        send_item(0, 0, 0, 32'd7211, 0, 12'hFFF, -16'sd1);   // held weight
        send_item(0, 0, 0, 32'd7212, 1, 12'h400, 16'sh8000); // clamped low
        send_item(0, 0, 0, 32'd7213, 1, 12'h000, 16'sd5);
        send_item(0, 0, 1, 32'd7214, 0, 12'h000, 16'sd0);    // toggle off from on
        send_item(0, 0, 1, 32'hFFFF_F000, 0, 12'h000, 16'sd0);
        send_item(0, 0, 0, 32'h0000_0100, 1, 12'h002, 16'sd300); // prepare across wrap
        send_item(0, 1, 0, 32'h0000_0101, 0, 12'h000, 16'sd0);
        send_item(0, 1, 1, 32'hFFFF_FF00, 0, 12'h000, 16'sd0);
        send_item(0, 0, 0, 32'h0000_0A00, 1, 12'hFFF, 16'sd0);
        send_item(0, 0, 0, 32'h0000_0C00, 1, 12'hFFF, 16'sd0);
        tick_now = 32'h0000_2000;

        for (k = 0; k < SETTINGS_CNT; k++) begin
            wait_drained();
            stride = 6;
            case (k)
                0: apply_setting(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
                1: begin
                    apply_setting(24'hFF_FFFF, 24'hFF_FFFF, 24'd255, 24'd4095, 24'd32767);
                    stride = 8000000;
                    // saturating streak needs a long unbroken black run
                    run_sequence(265, 100, stride, 1, 1'b1);
                end
                2: apply_setting(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
                default: apply_setting(24'($urandom_range(1, 24)), 24'($urandom_range(1, 24)),
                                       {16'($urandom), 8'($urandom_range(1, 6))},
                                       {12'($urandom), 12'($urandom)},
                                       {9'($urandom), 15'($urandom)});
            endcase
            goal = sent_items + ITEMS_PER_SET;
            while (sent_items < goal) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_sequence($urandom_range(4, 24), $urandom_range(20, 90), stride,
                                 $urandom_range(1, 2), 1'b0);
                end else begin
                    calm_in = 1'b0;
                    repeat ($urandom_range(1, 4)) begin
                        tick_now = step_tick(stride);
                        send_item($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 2) == 0, tick_now, $urandom_range(0, 1),
                                  12'($urandom), 16'($urandom));
                    end
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("drive_run_mode_sequencer_core: match");
        else
            $display("drive_run_mode_sequencer_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
src/drms_pkg.sv
src/drive_run_mode_sequencer_core.sv
bench/drms_result_checker.sv
bench/drive_run_mode_sequencer_core_tb.sv
